/* hw/rtl/vcl_pkg.sv */
package vcl_pkg;

    // Default field width of the velocity fields
    localparam int VEL_WIDTH_DEF = 16;

    // Limit registers are unsigned Q5.10
    localparam int REG_W = 15;

    // Configuration register index
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_SPEED      = 3'd0,
        REG_MIN_SPEED      = 3'd1,
        REG_MAX_SPEED_STEP = 3'd2,
        REG_MAX_TURN_RATE  = 3'd3,
        REG_MIN_TURN_RATE  = 3'd4,
        REG_MAX_TURN_STEP  = 3'd5
    } t_cfg_idx;

    // Reset values of the limit registers
    localparam logic [REG_W-1:0] RST_MAX_SPEED      = 15'd512;
    localparam logic [REG_W-1:0] RST_MIN_SPEED      = 15'd0;
    localparam logic [REG_W-1:0] RST_MAX_SPEED_STEP = 15'd512;
    localparam logic [REG_W-1:0] RST_MAX_TURN_RATE  = 15'd1608;
    localparam logic [REG_W-1:0] RST_MIN_TURN_RATE  = 15'd0;
    localparam logic [REG_W-1:0] RST_MAX_TURN_STEP  = 15'd1608;

endpackage

/* hw/rtl/vcl_if.sv */
// Measurement and target channel
interface vcl_in_if #(
    parameter int W = vcl_pkg::VEL_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] lin_vel_x;
    logic signed [W-1:0] lin_vel_y;
    logic signed [W-1:0] yaw_rate;
    logic signed [W-1:0] speed_target;
    logic signed [W-1:0] turn_target;

    modport source (
        output valid, lin_vel_x, lin_vel_y, yaw_rate, speed_target, turn_target,
        input  ready
    );
    modport sink (
        input  valid, lin_vel_x, lin_vel_y, yaw_rate, speed_target, turn_target,
        output ready
    );
endinterface

// Limited command channel
interface vcl_out_if #(
    parameter int W = vcl_pkg::VEL_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] speed_command;
    logic signed [W-1:0] turn_command;

    modport source (
        output valid, speed_command, turn_command,
        input  ready
    );
    modport sink (
        input  valid, speed_command, turn_command,
        output ready
    );
endinterface

// Register write channel
interface vcl_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [vcl_pkg::CFG_IDX_W-1:0] index;
    logic [vcl_pkg::REG_W-1:0]     data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

/* hw/rtl/vcl_sqrt_cell.sv */
// One digit of the pipelined integer square root: decides result bit BIT
// and hands remainder, partial root and side payload to the next cell.
module vcl_sqrt_cell #(
    parameter int W     = 16,
    parameter int BIT   = 0,
    parameter int PAY_W = 48
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_valid,
    input  logic [2*W-1:0]   i_rem,
    input  logic [W-1:0]     i_root,
    input  logic [PAY_W-1:0] i_pay,
    output logic             o_valid,
    output logic [2*W-1:0]   o_rem,
    output logic [W-1:0]     o_root,
    output logic [PAY_W-1:0] o_pay
);
    localparam int S = 2 * W;
    localparam logic [S-1:0] ONE_SQ = S'(1) << (2 * BIT);
    localparam logic [W-1:0] ONE_Q  = W'(1) << BIT;

    logic             r_valid;
    logic [S-1:0]     r_rem;
    logic [W-1:0]     r_root;
    logic [PAY_W-1:0] r_pay;
    logic [S-1:0]     trial;
    logic             take;

    // (Q + 2^b)^2 - Q^2 = Q*2^(b+1) + 4^b, bits are disjoint
    assign trial = (S'(i_root) << (BIT + 1)) | ONE_SQ;
    assign take  = (i_rem >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem  <= take ? (i_rem - trial) : i_rem;
            r_root <= take ? (i_root | ONE_Q) : i_root;
            r_pay  <= i_pay;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_pay   = r_pay;
endmodule

/* hw/rtl/vcl_limit.sv */
// Step and magnitude limiter, three register stages:
// step clamp, command sum, magnitude clamp with field saturation.
module vcl_limit #(
    parameter int W = 16
) (
    input  logic                      i_clk,
    input  logic                      i_adv,
    input  logic signed [W-1:0]       i_meas,
    input  logic signed [W-1:0]       i_target,
    input  logic [vcl_pkg::REG_W-1:0] i_step,
    input  logic [vcl_pkg::REG_W-1:0] i_vmax,
    input  logic [vcl_pkg::REG_W-1:0] i_vmin,
    output logic signed [W-1:0]       o_cmd
);
    import vcl_pkg::*;

    localparam int E = ((W > REG_W + 1) ? W : REG_W + 1) + 3;
    localparam logic signed [E-1:0] FIELD_MAX = E'((64'd1 << (W - 1)) - 64'd1);
    localparam logic signed [E-1:0] FIELD_MIN = -FIELD_MAX - E'(1);

    logic signed [E-1:0] step_e, vmax_e, vmin_e;
    logic signed [E-1:0] diff, d_clamp;
    logic signed [E-1:0] r_meas, r_d, r_cmd;
    logic signed [E-1:0] mag, lim, sat;
    logic                neg;
    logic signed [W-1:0] r_out;

    assign step_e = signed'({{(E - REG_W){1'b0}}, i_step});
    assign vmax_e = signed'({{(E - REG_W){1'b0}}, i_vmax});
    assign vmin_e = signed'({{(E - REG_W){1'b0}}, i_vmin});

    // Stage 1: clamp the step toward the target
    always_comb begin
        diff = E'(i_target) - E'(i_meas);
        if (diff > step_e) begin
            d_clamp = step_e;
        end else if (diff < -step_e) begin
            d_clamp = -step_e;
        end else begin
            d_clamp = diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_meas <= E'(i_meas);
            r_d    <= d_clamp;
        end
    end

    // Stage 2: stepped command
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_cmd <= r_meas + r_d;
        end
    end

    // Stage 3: magnitude window, sign kept, zero counts as positive
    always_comb begin
        neg = r_cmd[E-1];
        mag = neg ? -r_cmd : r_cmd;
        if (mag > vmax_e) begin
            lim = neg ? -vmax_e : vmax_e;
        end else if (mag < vmin_e) begin
            lim = neg ? -vmin_e : vmin_e;
        end else begin
            lim = r_cmd;
        end
        if (lim > FIELD_MAX) begin
            sat = FIELD_MAX;
        end else if (lim < FIELD_MIN) begin
            sat = FIELD_MIN;
        end else begin
            sat = lim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_out <= W'(sat);
        end
    end

    assign o_cmd = r_out;
endmodule

/* hw/rtl/velocity_command_limiter.sv */
// Velocity command limiter.
// Path from input transaction to result: 3 front stages, one square-root cell
// per result bit, 3 limiter stages.
// Throughput: one transaction per cycle; the whole pipe holds only on output stall.
// Reset: synchronous active-low; clears all valid flags, limit registers take
// their default values; both input channels are held not ready during reset.
module velocity_command_limiter #(
    parameter int VEL_WIDTH = vcl_pkg::VEL_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vcl_in_if.sink    i_meas,
    vcl_cfg_if.sink   i_cfg,
    vcl_out_if.source o_cmd
);
    import vcl_pkg::*;

    localparam int W  = VEL_WIDTH;
    localparam int S  = 2 * W;
    localparam int PW = 3 * W;
    localparam int E  = ((W > REG_W + 1) ? W : REG_W + 1) + 2;
    localparam logic signed [W-1:0] FIELD_MAX = {1'b0, {(W - 1){1'b1}}};

    // Limit registers
    logic [REG_W-1:0] r_max_speed, r_min_speed, r_max_speed_step;
    logic [REG_W-1:0] r_max_turn_rate, r_min_turn_rate, r_max_turn_step;

    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed      <= RST_MAX_SPEED;
            r_min_speed      <= RST_MIN_SPEED;
            r_max_speed_step <= RST_MAX_SPEED_STEP;
            r_max_turn_rate  <= RST_MAX_TURN_RATE;
            r_min_turn_rate  <= RST_MIN_TURN_RATE;
            r_max_turn_step  <= RST_MAX_TURN_STEP;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_MAX_SPEED:      r_max_speed      <= i_cfg.data;
                REG_MIN_SPEED:      r_min_speed      <= i_cfg.data;
                REG_MAX_SPEED_STEP: r_max_speed_step <= i_cfg.data;
                REG_MAX_TURN_RATE:  r_max_turn_rate  <= i_cfg.data;
                REG_MIN_TURN_RATE:  r_min_turn_rate  <= i_cfg.data;
                REG_MAX_TURN_STEP:  r_max_turn_step  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Pipe moves unless the output register holds an untaken result
    logic       adv;
    logic [2:0] r_f_valid;
    logic [2:0] r_e_valid;

    assign adv          = !r_e_valid[2] || o_cmd.ready;
    assign i_meas.ready = adv && i_rst_n;

    // Front stage 1: magnitudes and angular target clamp
    logic [W-1:0]        abs_x, abs_y;
    logic signed [E-1:0] wd_e, mtr_e;
    logic signed [W-1:0] wd_clamp;

    assign abs_x = i_meas.lin_vel_x[W-1] ? (~i_meas.lin_vel_x + W'(1)) : i_meas.lin_vel_x;
    assign abs_y = i_meas.lin_vel_y[W-1] ? (~i_meas.lin_vel_y + W'(1)) : i_meas.lin_vel_y;
    assign wd_e  = E'(i_meas.turn_target);
    assign mtr_e = signed'({{(E - REG_W){1'b0}}, r_max_turn_rate});

    always_comb begin
        if (wd_e > mtr_e) begin
            wd_clamp = W'(mtr_e);
        end else if (wd_e < -mtr_e) begin
            wd_clamp = W'(-mtr_e);
        end else begin
            wd_clamp = i_meas.turn_target;
        end
    end

    logic [W-1:0]  r_f1_ax, r_f1_ay;
    logic [PW-1:0] r_f1_pay, r_f2_pay, r_f3_pay;
    logic [S-1:0]  r_f2_sqx, r_f2_sqy, r_f3_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= '0;
        end else if (adv) begin
            r_f_valid <= {r_f_valid[1:0], i_meas.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f1_ax  <= abs_x;
            r_f1_ay  <= abs_y;
            r_f1_pay <= {wd_clamp, i_meas.speed_target, i_meas.yaw_rate};
            // Front stage 2: squares
            r_f2_sqx <= S'(r_f1_ax) * S'(r_f1_ax);
            r_f2_sqy <= S'(r_f1_ay) * S'(r_f1_ay);
            r_f2_pay <= r_f1_pay;
            // Front stage 3: sum of squares
            r_f3_sum <= r_f2_sqx + r_f2_sqy;
            r_f3_pay <= r_f2_pay;
        end
    end

    // Square-root cell row, most significant result bit first
    logic          cell_valid [W+1];
    logic [S-1:0]  cell_rem   [W+1];
    logic [W-1:0]  cell_root  [W+1];
    logic [PW-1:0] cell_pay   [W+1];

    assign cell_valid[0] = r_f_valid[2];
    assign cell_rem[0]   = r_f3_sum;
    assign cell_root[0]  = '0;
    assign cell_pay[0]   = r_f3_pay;

    for (genvar k = 0; k < W; k++) begin : g_cell
        vcl_sqrt_cell #(
            .W    (W),
            .BIT  (W - 1 - k),
            .PAY_W(PW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_adv  (adv),
            .i_valid(cell_valid[k]),
            .i_rem  (cell_rem[k]),
            .i_root (cell_root[k]),
            .i_pay  (cell_pay[k]),
            .o_valid(cell_valid[k+1]),
            .o_rem  (cell_rem[k+1]),
            .o_root (cell_root[k+1]),
            .o_pay  (cell_pay[k+1])
        );
    end

    // Measured speed saturates to the largest field value
    logic signed [W-1:0] speed_meas;
    logic signed [W-1:0] yaw_meas, speed_tgt, turn_tgt;
    logic signed [W-1:0] lin_cmd, ang_cmd;

    assign speed_meas = cell_root[W][W-1] ? FIELD_MAX : signed'(cell_root[W]);
    assign yaw_meas   = signed'(cell_pay[W][W-1:0]);
    assign speed_tgt  = signed'(cell_pay[W][2*W-1:W]);
    assign turn_tgt   = signed'(cell_pay[W][3*W-1:2*W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= '0;
        end else if (adv) begin
            r_e_valid <= {r_e_valid[1:0], cell_valid[W]};
        end
    end

    vcl_limit #(.W(W)) u_lin (
        .i_clk   (i_clk),
        .i_adv   (adv),
        .i_meas  (speed_meas),
        .i_target(speed_tgt),
        .i_step  (r_max_speed_step),
        .i_vmax  (r_max_speed),
        .i_vmin  (r_min_speed),
        .o_cmd   (lin_cmd)
    );

    vcl_limit #(.W(W)) u_ang (
        .i_clk   (i_clk),
        .i_adv   (adv),
        .i_meas  (yaw_meas),
        .i_target(turn_tgt),
        .i_step  (r_max_turn_step),
        .i_vmax  (r_max_turn_rate),
        .i_vmin  (r_min_turn_rate),
        .o_cmd   (ang_cmd)
    );

    assign o_cmd.valid         = r_e_valid[2];
    assign o_cmd.speed_command = lin_cmd;
    assign o_cmd.turn_command  = ang_cmd;
endmodule
